@@ sv/mas_pkg.sv @@
`default_nettype none

package mas_pkg;

   // Field widths
   localparam int TIME_WIDTH   = 32;
   localparam int SAMPLE_WIDTH = 12;
   localparam int HOURS_WIDTH  = 8;
   localparam int INDEX_WIDTH  = 3;

   // Sensor fault bound and time base
   localparam logic [SAMPLE_WIDTH-1:0] FAULT_HIGH  = 12'd4090;
   localparam logic [21:0]             MS_PER_HOUR = 22'd3600000;
   localparam int                      LOCKOUT_PRODUCT_WIDTH = HOURS_WIDTH + 22;

   // Register reset values
   localparam logic [SAMPLE_WIDTH-1:0] DRY_THRESHOLD_RESET   = 12'd1228;
   localparam logic [TIME_WIDTH-1:0]   LOCKOUT_MS_RESET      = 32'd64800000;
   localparam logic [SAMPLE_WIDTH-1:0] JUMP_THRESHOLD_RESET  = 12'd330;
   localparam logic [SAMPLE_WIDTH-1:0] NIGHT_SOLAR_RESET     = 12'd100;
   localparam logic [TIME_WIDTH-1:0]   HAPPY_DURATION_RESET  = 32'd7200000;
   localparam logic [TIME_WIDTH-1:0]   DRY_CONFIRM_RESET     = 32'd21600000;
   localparam logic [TIME_WIDTH-1:0]   NIGHT_CONFIRM_RESET   = 32'd1800000;

   // LED pattern shown while night is confirmed
   localparam logic [1:0] LED_OFF = 2'd0;

   typedef enum logic [1:0] {
      ST_SLEEPING = 2'd0,
      ST_THIRSTY  = 2'd1,
      ST_HAPPY    = 2'd2,
      ST_SICK     = 2'd3
   } plant_state_type;

   typedef enum logic [INDEX_WIDTH-1:0] {
      CSR_DRY_THRESHOLD  = 3'd0,
      CSR_LOCKOUT_HOURS  = 3'd1,
      CSR_JUMP_THRESHOLD = 3'd2,
      CSR_NIGHT_SOLAR    = 3'd3,
      CSR_HAPPY_DURATION = 3'd4,
      CSR_DRY_CONFIRM    = 3'd5,
      CSR_NIGHT_CONFIRM  = 3'd6
   } csr_index_type;

   // Live configuration, lockout already scaled to milliseconds
   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] dry_threshold;
      logic [TIME_WIDTH-1:0]   lockout_ms;
      logic [SAMPLE_WIDTH-1:0] jump_threshold;
      logic [SAMPLE_WIDTH-1:0] night_solar_threshold;
      logic [TIME_WIDTH-1:0]   happy_hold_ms;
      logic [TIME_WIDTH-1:0]   dry_wait_ms;
      logic [TIME_WIDTH-1:0]   dark_wait_ms;
   } cfg_type;

endpackage

`default_nettype wire

@@ sv/mas_csr.sv @@
`default_nettype none

module mas_csr import mas_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   input  wire logic [INDEX_WIDTH-1:0] csr_index,
   input  wire logic [TIME_WIDTH-1:0]  csr_wdata,
   output cfg_type                     cfg
);

   cfg_type                             cfg_ff;
   cfg_type                             cfg_in;
   logic [LOCKOUT_PRODUCT_WIDTH-1:0]    lockout_product;

   // Scale hours to milliseconds once, at write time
   assign lockout_product = LOCKOUT_PRODUCT_WIDTH'(csr_wdata[HOURS_WIDTH-1:0])
                          * LOCKOUT_PRODUCT_WIDTH'(MS_PER_HOUR);

   // Decode the write beat; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_DRY_THRESHOLD:  cfg_in.dry_threshold = csr_wdata[SAMPLE_WIDTH-1:0];
            CSR_LOCKOUT_HOURS:  cfg_in.lockout_ms = TIME_WIDTH'(lockout_product);
            CSR_JUMP_THRESHOLD: cfg_in.jump_threshold = csr_wdata[SAMPLE_WIDTH-1:0];
            CSR_NIGHT_SOLAR:    cfg_in.night_solar_threshold = csr_wdata[SAMPLE_WIDTH-1:0];
            CSR_HAPPY_DURATION: cfg_in.happy_hold_ms = csr_wdata;
            CSR_DRY_CONFIRM:    cfg_in.dry_wait_ms = csr_wdata;
            CSR_NIGHT_CONFIRM:  cfg_in.dark_wait_ms = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dry_threshold         <= DRY_THRESHOLD_RESET;
         cfg_ff.lockout_ms            <= LOCKOUT_MS_RESET;
         cfg_ff.jump_threshold        <= JUMP_THRESHOLD_RESET;
         cfg_ff.night_solar_threshold <= NIGHT_SOLAR_RESET;
         cfg_ff.happy_hold_ms         <= HAPPY_DURATION_RESET;
         cfg_ff.dry_wait_ms           <= DRY_CONFIRM_RESET;
         cfg_ff.dark_wait_ms          <= NIGHT_CONFIRM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ sv/moisture_alert_state_machine_unit.sv @@
// Plant moisture alert unit.
// Request channel (req_valid/req_ready) carries one sample beat: millisecond
// time, moisture and solar readings. Response channel (rsp_valid/rsp_ready)
// returns exactly one result beat per sample: plant state, night flag, LED
// pattern, watering and sensor fault flags.
// Configuration channel (csr_valid/csr_ready, csr_index, csr_wdata) writes
// the seven registers; csr_ready is always high, unknown indexes are dropped.
// Write registers only while no sample is in flight.
// The request beat is registered in the input register, then the state update
// writes the result register. Throughput: one sample per cycle while the
// receiver does not stall; the state update is a single pass of compares and
// 32-bit subtracts.
// The receiver may stall: the result register holds, the input register
// still takes one more sample, and req_ready drops once both are full.
// Reset restores register defaults, state sleeping, all timers idle. The
// first sample after reset only loads the previous moisture reading; its
// result reports the held state with watered and sensor_fault low.
`default_nettype none

module moisture_alert_state_machine_unit import mas_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [TIME_WIDTH-1:0]   req_now_ms,
   input  wire logic [SAMPLE_WIDTH-1:0] req_moisture,
   input  wire logic [SAMPLE_WIDTH-1:0] req_solar,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [1:0]                   rsp_plant_state,
   output logic                         rsp_night,
   output logic [1:0]                   rsp_led_pattern,
   output logic                         rsp_watered,
   output logic                         rsp_sensor_fault,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [TIME_WIDTH-1:0]   csr_wdata
);

   cfg_type cfg;

   // Input register
   logic                    s1_valid_ff;
   logic [TIME_WIDTH-1:0]   s1_now_ff;
   logic [SAMPLE_WIDTH-1:0] s1_moist_ff;
   logic [SAMPLE_WIDTH-1:0] s1_solar_ff;

   // Plant state
   plant_state_type         state_ff, state_in;
   logic [SAMPLE_WIDTH-1:0] prev_moist_ff;
   logic                    primed_ff, primed_in;
   logic [TIME_WIDTH-1:0]   dry_since_ff, dry_since_in;
   logic                    dry_timing_ff, dry_timing_in;
   logic [TIME_WIDTH-1:0]   happy_since_ff, happy_since_in;
   logic [TIME_WIDTH-1:0]   lockout_end_ff, lockout_end_in;
   logic [TIME_WIDTH-1:0]   dark_since_ff, dark_since_in;
   logic                    dark_timing_ff, dark_timing_in;
   logic                    night_ff, night_in;

   // Result register
   logic                    rsp_valid_ff;
   logic [1:0]              rsp_state_ff;
   logic                    rsp_night_ff;
   logic [1:0]              rsp_led_ff;
   logic                    rsp_watered_ff;
   logic                    rsp_fault_ff;

   logic                    advance;
   logic                    watered;
   logic                    fault;
   logic                    is_dark;
   logic                    is_dry;
   logic                    dark_met;
   logic                    dry_met;
   logic                    happy_met;
   logic                    after_lockout;
   logic [TIME_WIDTH-1:0]   dark_age;
   logic [TIME_WIDTH-1:0]   dry_age;
   logic [TIME_WIDTH-1:0]   happy_age;
   logic [TIME_WIDTH-1:0]   lockout_gap;
   logic [SAMPLE_WIDTH:0]   jump_level;
   logic                    rsp_watered_in;
   logic                    rsp_fault_in;

   mas_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign csr_ready = 1'b1;

   // Handshake: step when the result register is free or being drained
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   // Load the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_now_ff   <= req_now_ms;
         s1_moist_ff <= req_moisture;
         s1_solar_ff <= req_solar;
      end
   end

   // Sample conditions and wrapped time tests
   assign jump_level  = {1'b0, prev_moist_ff} + {1'b0, cfg.jump_threshold};
   assign watered     = {1'b0, s1_moist_ff} > jump_level;
   assign fault       = (s1_moist_ff == '0) || (s1_moist_ff >= FAULT_HIGH);
   assign is_dark     = s1_solar_ff < cfg.night_solar_threshold;
   assign is_dry      = s1_moist_ff < cfg.dry_threshold;
   assign dark_age    = s1_now_ff - dark_since_ff;
   assign dry_age     = s1_now_ff - dry_since_ff;
   assign happy_age   = s1_now_ff - happy_since_ff;
   assign lockout_gap = s1_now_ff - lockout_end_ff;
   // A timer that starts on this sample has zero age
   assign dark_met    = dark_timing_ff ? (dark_age >= cfg.dark_wait_ms)
                                       : (cfg.dark_wait_ms == '0);
   assign dry_met     = dry_timing_ff ? (dry_age >= cfg.dry_wait_ms)
                                      : (cfg.dry_wait_ms == '0);
   assign happy_met   = happy_age >= cfg.happy_hold_ms;
   assign after_lockout = (lockout_gap != '0) && !lockout_gap[TIME_WIDTH-1];

   // Next state and result fields
   always_comb begin
      state_in       = state_ff;
      primed_in      = 1'b1;
      dry_since_in   = dry_since_ff;
      dry_timing_in  = dry_timing_ff;
      happy_since_in = happy_since_ff;
      lockout_end_in = lockout_end_ff;
      dark_since_in  = dark_since_ff;
      dark_timing_in = dark_timing_ff;
      night_in       = night_ff;
      rsp_watered_in = 1'b0;
      rsp_fault_in   = 1'b0;

      if (primed_ff) begin
         rsp_watered_in = watered;
         rsp_fault_in   = fault;

         // Darkness timer and night flag
         if (is_dark) begin
            if (!dark_timing_ff) begin
               dark_since_in = s1_now_ff;
            end
            dark_timing_in = 1'b1;
            night_in       = night_ff || dark_met;
         end else begin
            dark_timing_in = 1'b0;
            night_in       = 1'b0;
         end

         // Plant state, by priority
         if (fault) begin
            state_in = ST_SICK;
         end else if (watered && after_lockout) begin
            state_in       = ST_HAPPY;
            happy_since_in = s1_now_ff;
            lockout_end_in = s1_now_ff + cfg.lockout_ms;
            dry_timing_in  = 1'b0;
         end else if (state_ff == ST_HAPPY) begin
            if (happy_met) begin
               state_in = ST_SLEEPING;
            end
         end else if (is_dry) begin
            if (!dry_timing_ff) begin
               dry_since_in = s1_now_ff;
            end
            dry_timing_in = 1'b1;
            if (dry_met && after_lockout) begin
               state_in = ST_THIRSTY;
            end
         end else begin
            dry_timing_in = 1'b0;
            unique case (state_ff)
               ST_THIRSTY: state_in = ST_SLEEPING;
               default:    state_in = state_ff;
            endcase
         end
      end
   end

   // Commit state on each step
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_SLEEPING;
         prev_moist_ff  <= '0;
         primed_ff      <= 1'b0;
         dry_since_ff   <= '0;
         dry_timing_ff  <= 1'b0;
         happy_since_ff <= '0;
         lockout_end_ff <= '0;
         dark_since_ff  <= '0;
         dark_timing_ff <= 1'b0;
         night_ff       <= 1'b0;
      end else if (advance) begin
         state_ff       <= state_in;
         prev_moist_ff  <= s1_moist_ff;
         primed_ff      <= primed_in;
         dry_since_ff   <= dry_since_in;
         dry_timing_ff  <= dry_timing_in;
         happy_since_ff <= happy_since_in;
         lockout_end_ff <= lockout_end_in;
         dark_since_ff  <= dark_since_in;
         dark_timing_ff <= dark_timing_in;
         night_ff       <= night_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_state_ff   <= state_in;
         rsp_night_ff   <= night_in;
         rsp_led_ff     <= night_in ? LED_OFF : state_in;
         rsp_watered_ff <= rsp_watered_in;
         rsp_fault_ff   <= rsp_fault_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_plant_state  = rsp_state_ff;
   assign rsp_night        = rsp_night_ff;
   assign rsp_led_pattern  = rsp_led_ff;
   assign rsp_watered      = rsp_watered_ff;
   assign rsp_sensor_fault = rsp_fault_ff;

   // A fault result always reports sick
   a_fault_sick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sensor_fault |-> rsp_plant_state == ST_SICK)
      else $error("fault result without sick state");

   // Night blanks the LED
   a_night_led: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_night |-> rsp_led_pattern == LED_OFF)
      else $error("LED lit during night");

   // Entering happy needs a watering jump
   a_happy_cause: assert property (@(posedge clock) disable iff (reset)
      advance && state_in == ST_HAPPY && state_ff != ST_HAPPY |-> rsp_watered_in)
      else $error("happy entered without watering");

   // Once primed, stays primed until reset
   a_primed_holds: assert property (@(posedge clock) disable iff (reset)
      primed_ff |=> primed_ff)
      else $error("primed flag dropped");

   // A held input sample is not overwritten
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_now_ff))
      else $error("input register overwritten while stalled");

endmodule

`default_nettype wire

@@ dv/moisture_alert_state_machine_unit_tb.sv @@
`timescale 1ns / 1ps

module moisture_alert_state_machine_unit_tb import mas_pkg::*; ();

   localparam int LIMIT_CYCLES = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [HOURS_WIDTH-1:0] LOCKOUT_HOURS_RESET = 8'd18;
   // Index past the last register: writes here must be dropped
   localparam logic [INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 3'd7;

   typedef struct packed {
      plant_state_type state;
      logic            night;
      logic [1:0]      led;
      logic            watered;
      logic            fault;
   } plant_report_type;

   // Block ports
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [TIME_WIDTH-1:0]   req_now_ms = '0;
   logic [SAMPLE_WIDTH-1:0] req_moisture = '0;
   logic [SAMPLE_WIDTH-1:0] req_solar = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [1:0]              rsp_plant_state;
   logic                    rsp_night;
   logic [1:0]              rsp_led_pattern;
   logic                    rsp_watered;
   logic                    rsp_sensor_fault;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [INDEX_WIDTH-1:0]  csr_index = '0;
   logic [TIME_WIDTH-1:0]   csr_wdata = '0;

   // Predicted configuration, starting from the reset values
   logic [SAMPLE_WIDTH-1:0] cfg_dry_thr = DRY_THRESHOLD_RESET;
   logic [HOURS_WIDTH-1:0]  cfg_lockout_hours = LOCKOUT_HOURS_RESET;
   logic [SAMPLE_WIDTH-1:0] cfg_jump = JUMP_THRESHOLD_RESET;
   logic [SAMPLE_WIDTH-1:0] cfg_night_solar = NIGHT_SOLAR_RESET;
   logic [TIME_WIDTH-1:0]   cfg_happy_ms = HAPPY_DURATION_RESET;
   logic [TIME_WIDTH-1:0]   cfg_dry_confirm = DRY_CONFIRM_RESET;
   logic [TIME_WIDTH-1:0]   cfg_night_confirm = NIGHT_CONFIRM_RESET;

   // Predicted plant state
   plant_state_type         pr_state = ST_SLEEPING;
   logic [SAMPLE_WIDTH-1:0] pr_prev_moist = '0;
   logic                    pr_primed = 1'b0;
   logic [TIME_WIDTH-1:0]   pr_dry_since = '0;
   logic                    pr_dry_timing = 1'b0;
   logic [TIME_WIDTH-1:0]   pr_happy_since = '0;
   logic [TIME_WIDTH-1:0]   pr_lockout_end = '0;
   logic [TIME_WIDTH-1:0]   pr_dark_since = '0;
   logic                    pr_dark_timing = 1'b0;
   logic                    pr_night = 1'b0;

   plant_report_type expected_reports[$];
   plant_report_type want_report;

   int error_count = 0;
   int cycle_count = 0;
   bit idle_on = 1'b1;
   int rsp_stall = 0;
   int hold_request = 0;
   int hold_left = 0;

   // Stimulus time base and sensor history
   logic [TIME_WIDTH-1:0] clock_ms = '0;
   int                    last_moisture = 0;
   bit                    sky_dark = 1'b0;

   moisture_alert_state_machine_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_now_ms       (req_now_ms),
      .req_moisture     (req_moisture),
      .req_solar        (req_solar),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_plant_state  (rsp_plant_state),
      .rsp_night        (rsp_night),
      .rsp_led_pattern  (rsp_led_pattern),
      .rsp_watered      (rsp_watered),
      .rsp_sensor_fault (rsp_sensor_fault),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Wrapping elapsed-time test
   function automatic bit span_reached(input logic [TIME_WIDTH-1:0] t,
                                       input logic [TIME_WIDTH-1:0] start,
                                       input logic [TIME_WIDTH-1:0] dur);
      logic [TIME_WIDTH-1:0] d;
      d = t - start;
      return d >= dur;
   endfunction

   // True once t is strictly later than the lockout end, within half the wrap
   function automatic bit past_lockout(input logic [TIME_WIDTH-1:0] t);
      logic [TIME_WIDTH-1:0] d;
      d = t - pr_lockout_end;
      return (d != '0) && !d[TIME_WIDTH-1];
   endfunction

   function automatic void apply_reg_write(input logic [INDEX_WIDTH-1:0] idx,
                                           input logic [TIME_WIDTH-1:0] data);
      case (idx)
         CSR_DRY_THRESHOLD:  cfg_dry_thr = data[SAMPLE_WIDTH-1:0];
         CSR_LOCKOUT_HOURS:  cfg_lockout_hours = data[HOURS_WIDTH-1:0];
         CSR_JUMP_THRESHOLD: cfg_jump = data[SAMPLE_WIDTH-1:0];
         CSR_NIGHT_SOLAR:    cfg_night_solar = data[SAMPLE_WIDTH-1:0];
         CSR_HAPPY_DURATION: cfg_happy_ms = data;
         CSR_DRY_CONFIRM:    cfg_dry_confirm = data;
         CSR_NIGHT_CONFIRM:  cfg_night_confirm = data;
         default: ;
      endcase
   endfunction

   // Advance the plant state by one sample and return the report it yields
   function automatic plant_report_type predict_sample(input logic [TIME_WIDTH-1:0] t,
                                                       input logic [SAMPLE_WIDTH-1:0] m,
                                                       input logic [SAMPLE_WIDTH-1:0] s);
      plant_report_type      r;
      logic [TIME_WIDTH-1:0] lock_ms;
      r = '0;
      if (!pr_primed) begin
         // First sample after reset only loads the moisture history
         pr_prev_moist = m;
         pr_primed = 1'b1;
      end else begin
         // Darkness timer and night flag
         if (s < cfg_night_solar) begin
            if (!pr_dark_timing) begin
               pr_dark_since = t;
               pr_dark_timing = 1'b1;
            end
            if (span_reached(t, pr_dark_since, cfg_night_confirm))
               pr_night = 1'b1;
         end else begin
            pr_dark_timing = 1'b0;
            pr_night = 1'b0;
         end

         r.watered = {1'b0, m} > ({1'b0, pr_prev_moist} + {1'b0, cfg_jump});
         r.fault = (m == '0) || (m >= FAULT_HIGH);

         // State transitions, fault first
         if (r.fault) begin
            pr_state = ST_SICK;
         end else if (r.watered && past_lockout(t)) begin
            pr_state = ST_HAPPY;
            pr_happy_since = t;
            lock_ms = cfg_lockout_hours * MS_PER_HOUR;
            pr_lockout_end = t + lock_ms;
            pr_dry_timing = 1'b0;
         end else if (pr_state == ST_HAPPY) begin
            if (span_reached(t, pr_happy_since, cfg_happy_ms))
               pr_state = ST_SLEEPING;
         end else if (m < cfg_dry_thr) begin
            if (!pr_dry_timing) begin
               pr_dry_since = t;
               pr_dry_timing = 1'b1;
            end
            if (span_reached(t, pr_dry_since, cfg_dry_confirm) && past_lockout(t))
               pr_state = ST_THIRSTY;
         end else begin
            pr_dry_timing = 1'b0;
            if (pr_state == ST_THIRSTY)
               pr_state = ST_SLEEPING;
         end
         pr_prev_moist = m;
      end
      r.state = pr_state;
      r.night = pr_night;
      r.led = pr_night ? LED_OFF : pr_state;
      return r;
   endfunction

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= 10)
         $display("ERROR at %0t: %s", $time, msg);
   endfunction

   function automatic void check_field(input string field, input int want, input int got);
      if (want != got)
         note_error($sformatf("%s expected %0d got %0d", field, want, got));
   endfunction

   // Track config writes, check result beats, predict each accepted sample
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            apply_reg_write(csr_index, csr_wdata);
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               note_error("result beat with no sample outstanding");
            end else begin
               want_report = expected_reports.pop_front();
               check_field("plant_state", want_report.state, rsp_plant_state);
               check_field("night", want_report.night, rsp_night);
               check_field("led_pattern", want_report.led, rsp_led_pattern);
               check_field("watered", want_report.watered, rsp_watered);
               check_field("sensor_fault", want_report.fault, rsp_sensor_fault);
            end
            rsp_stall = idle_on ? $urandom_range(0, 15) : 0;
         end
         if (req_valid && req_ready)
            expected_reports.push_back(predict_sample(req_now_ms, req_moisture, req_solar));
      end
   end

   // Receiver: long hold-off when requested, otherwise a drawn stall per beat
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // Offer one sample beat after a drawn gap and hold it until accepted
   task automatic send_sample(input logic [TIME_WIDTH-1:0] t,
                              input logic [SAMPLE_WIDTH-1:0] m,
                              input logic [SAMPLE_WIDTH-1:0] s);
      int gap;
      gap = idle_on ? $urandom_range(0, 15) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_now_ms <= t;
      req_moisture <= m;
      req_solar <= s;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid, wait for every outstanding result, then let the pipe empty
   task automatic settle_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [INDEX_WIDTH-1:0] idx,
                            input logic [TIME_WIDTH-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Write all seven registers; unused upper data bits carry noise
   task automatic write_all_regs(input logic [SAMPLE_WIDTH-1:0] dry,
                                 input logic [HOURS_WIDTH-1:0] hours,
                                 input logic [SAMPLE_WIDTH-1:0] jump,
                                 input logic [SAMPLE_WIDTH-1:0] dark,
                                 input logic [TIME_WIDTH-1:0] happy,
                                 input logic [TIME_WIDTH-1:0] dry_conf,
                                 input logic [TIME_WIDTH-1:0] night_conf);
      logic [TIME_WIDTH-1:0] junk;
      junk = $urandom();
      write_reg(CSR_DRY_THRESHOLD, {junk[31:12], dry});
      write_reg(CSR_LOCKOUT_HOURS, {junk[31:8], hours});
      write_reg(CSR_JUMP_THRESHOLD, {~junk[31:12], jump});
      write_reg(CSR_NIGHT_SOLAR, {junk[19:0], dark});
      write_reg(CSR_HAPPY_DURATION, happy);
      write_reg(CSR_DRY_CONFIRM, dry_conf);
      write_reg(CSR_NIGHT_CONFIRM, night_conf);
   endtask

   // Next sample: time moves on or repeats, moisture drifts with waterings and faults,
   // light stays dark or bright for stretches
   task automatic send_random_sample();
      int                      pick;
      int                      level;
      logic [SAMPLE_WIDTH-1:0] solar_val;
      pick = $urandom_range(0, 99);
      if (pick < 5)
         clock_ms = clock_ms + $urandom();
      else if (pick < 60 && pick >= 15)
         clock_ms = clock_ms + $urandom_range(1, 100000);
      else if (pick >= 60)
         clock_ms = clock_ms + $urandom_range(100000, 4000000);

      level = last_moisture;
      pick = $urandom_range(0, 99);
      if (pick < 8)
         level = $urandom_range(0, 1) ? 0 : int'($urandom_range(4090, 4095));
      else if (pick < 20)
         level = level + int'(cfg_jump) + int'($urandom_range(1, 600));
      else if (pick < 30)
         level = $urandom_range(0, 4095);
      else
         level = level + int'($urandom_range(0, 300)) - 150;
      // Keep drift and waterings inside the healthy range
      if (pick >= 8 && !(pick >= 20 && pick < 30)) begin
         if (level < 1) level = 1;
         if (level > 4089) level = 4089;
      end
      last_moisture = level;

      if ($urandom_range(0, 9) == 0)
         sky_dark = !sky_dark;
      if (sky_dark && cfg_night_solar != '0)
         solar_val = SAMPLE_WIDTH'($urandom_range(0, int'(cfg_night_solar) - 1));
      else
         solar_val = SAMPLE_WIDTH'($urandom_range(0, 4095));

      send_sample(clock_ms, 12'(level), solar_val);
   endtask

   // Reset defaults: priming, faults, lockout at reset, happy, thirst, night
   task automatic test_directed_sequence();
      idle_on = 1'b1;
      send_sample(32'd0, 12'd4095, 12'd0);
      send_sample(32'd0, 12'd0, 12'd4095);
      send_sample(32'd5, 12'd4090, 12'd4095);
      send_sample(32'd10, 12'd4089, 12'd0);
      send_sample(32'h8000_0000, 12'd100, 12'd0);
      send_sample(32'h8000_0001, 12'd1000, 12'd0);
      send_sample(32'hFFFF_FFFF, 12'd2000, 12'd4095);
      send_sample(32'd100, 12'd3000, 12'd2048);
      send_sample(32'd200, 12'd3500, 12'd2048);
      send_sample(32'd7200100, 12'd3500, 12'd2048);
      send_sample(32'd8000000, 12'd500, 12'd2048);
      send_sample(32'd29600000, 12'd500, 12'd2048);
      send_sample(32'd70000000, 12'd500, 12'd2048);
      send_sample(32'd71000000, 12'd3000, 12'd2048);
      send_sample(32'd72000000, 12'd2000, 12'd2048);
      send_sample(32'd80000000, 12'd1000, 12'd2048);
      send_sample(32'd81000000, 12'd1000, 12'd2048);
      send_sample(32'd103000000, 12'd1000, 12'd50);
      send_sample(32'd140000000, 12'd1000, 12'd50);
      send_sample(32'd141000000, 12'd1300, 12'd100);
      send_sample(32'd141000000, 12'd1300, 12'd4095);
      clock_ms = 32'd141000000;
      last_moisture = 1300;
   endtask

   // All registers at zero (zero durations met at once), then all at maximum
   task automatic test_register_extremes();
      settle_idle();
      write_all_regs('0, '0, '0, '0, '0, '0, '0);
      write_reg(CSR_UNUSED_INDEX, $urandom());
      repeat (25) send_random_sample();
      settle_idle();
      write_all_regs('1, '1, '1, '1, '1, '1, '1);
      write_reg(CSR_UNUSED_INDEX, $urandom());
      repeat (25) send_random_sample();
   endtask

   // Random settings per phase; one phase without idling, one across the wrap
   task automatic test_random_samples();
      for (int phase = 0; phase < 7; phase++) begin
         settle_idle();
         idle_on = (phase != 2);
         if (phase == 4)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000000);
         write_all_regs(SAMPLE_WIDTH'($urandom_range(500, 3000)),
                        HOURS_WIDTH'($urandom_range(0, 2)),
                        SAMPLE_WIDTH'($urandom_range(50, 800)),
                        SAMPLE_WIDTH'($urandom_range(200, 2000)),
                        $urandom_range(0, 5000000), $urandom_range(0, 10000000),
                        $urandom_range(0, 5000000));
         repeat (65) send_random_sample();
      end
   endtask

   // Receiver holds off while the sender keeps offering, then the sender
   // pauses until every result is back
   task automatic test_backpressure();
      settle_idle();
      write_all_regs(12'd1500, 8'd1, 12'd300, 12'd800, 32'd2000000, 32'd3000000,
                     32'd1000000);
      idle_on = 1'b0;
      @(posedge clock);
      hold_request = 300;
      repeat (30) send_random_sample();
      settle_idle();
      idle_on = 1'b1;
      repeat (20) send_random_sample();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_sequence();
      test_register_extremes();
      test_random_samples();
      test_backpressure();
      settle_idle();
      if (error_count == 0 && expected_reports.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
